// ===== rtl/core/tnks_pkg.sv =====
// tnks_pkg: shared types and codes for the top-n key selector
// holds the per-cycle cell command and the config register constants
// no dependencies
package tnks_pkg;

    // command broadcast to every cell of the sorted row
    localparam logic [1:0] MODE_HOLD    = 2'd0;
    localparam logic [1:0] MODE_INSERT  = 2'd1;
    localparam logic [1:0] MODE_REPLACE = 2'd2;
    localparam logic [1:0] MODE_POP     = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
    } cell_ctrl_t;

    // config register map
    localparam int          CFG_DATA_BITS = 32;
    localparam int          CAP_BITS      = 9;
    localparam logic        REG_CAPACITY  = 1'b0;
    localparam int unsigned CAP_RESET     = 256;

endpackage

// ===== rtl/core/tnks_cell.sv =====
// tnks_cell: one slot of the sorted entry row
// holds one key/tag pair, compares it to the incoming entry and shifts with its neighbors
// depends on tnks_pkg
module tnks_cell #(
    parameter int KEY_BITS = 31,
    parameter int TAG_BITS = 16,
    parameter int CNT_W    = 9,
    parameter int INDEX    = 0
) (
    input  logic                clk,
    input  tnks_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]    count,
    input  logic [KEY_BITS-1:0] new_key,
    input  logic [TAG_BITS-1:0] new_tag,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [TAG_BITS-1:0] left_tag,
    input  logic                left_lt,
    input  logic [KEY_BITS-1:0] right_key,
    input  logic [TAG_BITS-1:0] right_tag,
    input  logic                right_lt,
    output logic [KEY_BITS-1:0] key,
    output logic [TAG_BITS-1:0] tag,
    output logic                lt
);
    import tnks_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;
    logic                valid;

    // slot holds a live entry when it sits below the fill count
    assign valid = CNT_W'(INDEX) < count;

    // live entry orders before the incoming one (key, then tag)
    assign lt = valid && ((key_reg < new_key) || ((key_reg == new_key) && (tag_reg < new_tag)));

    // pick from self, neighbors or the incoming entry
    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        case (ctrl.mode)
            MODE_INSERT:
            begin
                if (!lt)
                begin
                    if (left_lt)
                    begin
                        key_next = new_key;
                        tag_next = new_tag;
                    end
                    else
                    begin
                        key_next = left_key;
                        tag_next = left_tag;
                    end
                end
            end
            MODE_REPLACE:
            begin
                if (right_lt)
                begin
                    key_next = right_key;
                    tag_next = right_tag;
                end
                else if (lt)
                begin
                    key_next = new_key;
                    tag_next = new_tag;
                end
            end
            MODE_POP:
            begin
                key_next = right_key;
                tag_next = right_tag;
            end
            default:
            begin
                key_next = key_reg;
                tag_next = tag_reg;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

// ===== rtl/core/top_n_key_selector.sv =====
// top_n_key_selector: keeps the capacity entries with the largest keys of a stream
// top level: sorted row of tnks_cell slots, fill count, apb capacity register
// depends on tnks_pkg and tnks_cell

// Entries are kept sorted smallest-first in a row of DEPTH cells; every
// request (offer or pop) is accepted on arrival, so busy stays low and
// a new request may come each clock. Each cell compares its own entry with
// the offered one and takes its own, a neighbor's or the offered entry, so
// the row shifts in one step. A pop's result (out_key, out_tag, was_empty)
// shows with out_valid for exactly one cycle, the cycle after the request;
// the receiver cannot stall it. Offers give no result. Capacity (byte
// address 0) is written only while the store is empty; other writes are
// dropped.
module top_n_key_selector #(
    parameter int DEPTH    = 256,
    parameter int KEY_BITS = 31,
    parameter int TAG_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 start,
    output logic                 busy,
    input  logic                 opcode,
    input  logic [KEY_BITS-1:0]  key,
    input  logic [TAG_BITS-1:0]  tag,
    // result channel
    output logic                 out_valid,
    output logic [KEY_BITS-1:0]  out_key,
    output logic [TAG_BITS-1:0]  out_tag,
    output logic                 was_empty,
    // config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [tnks_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [tnks_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                 pready
);
    import tnks_pkg::*;

    localparam int          CNT_W     = $clog2(DEPTH + 1);
    localparam int unsigned CAP_INIT  = (CAP_RESET < DEPTH) ? CAP_RESET : DEPTH;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    cap_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [KEY_BITS-1:0] out_key_reg;
    logic [KEY_BITS-1:0] out_key_next;
    logic [TAG_BITS-1:0] out_tag_reg;
    logic [TAG_BITS-1:0] out_tag_next;
    logic                was_empty_reg;
    logic                was_empty_next;
    cell_ctrl_t          ctrl;
    logic                accept;
    logic                cfg_write;
    logic [CAP_BITS-1:0] cap_value;

    logic [KEY_BITS-1:0] cell_key [DEPTH];
    logic [TAG_BITS-1:0] cell_tag [DEPTH];
    logic                cell_lt  [DEPTH];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    // sorted row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_BITS-1:0] lkey;
        logic [TAG_BITS-1:0] ltag;
        logic                llt;
        logic [KEY_BITS-1:0] rkey;
        logic [TAG_BITS-1:0] rtag;
        logic                rlt;

        if (i == 0)
        begin : g_first
            assign lkey = key;
            assign ltag = tag;
            assign llt  = 1'b1;
        end
        else
        begin : g_inner_l
            assign lkey = cell_key[i-1];
            assign ltag = cell_tag[i-1];
            assign llt  = cell_lt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rkey = cell_key[i];
            assign rtag = cell_tag[i];
            assign rlt  = 1'b0;
        end
        else
        begin : g_inner_r
            assign rkey = cell_key[i+1];
            assign rtag = cell_tag[i+1];
            assign rlt  = cell_lt[i+1];
        end

        tnks_cell #(
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS),
            .CNT_W    (CNT_W),
            .INDEX    (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .new_key   (key),
            .new_tag   (tag),
            .left_key  (lkey),
            .left_tag  (ltag),
            .left_lt   (llt),
            .right_key (rkey),
            .right_tag (rtag),
            .right_lt  (rlt),
            .key       (cell_key[i]),
            .tag       (cell_tag[i]),
            .lt        (cell_lt[i])
        );
    end

    // request decode, count update and pop result
    always_comb
    begin
        ctrl.mode      = MODE_HOLD;
        count_next     = count_reg;
        out_valid_next = 1'b0;
        out_key_next   = cell_key[0];
        out_tag_next   = cell_tag[0];
        was_empty_next = 1'b0;
        if (accept)
        begin
            if (opcode)
            begin
                out_valid_next = 1'b1;
                if (count_reg != '0)
                begin
                    ctrl.mode  = MODE_POP;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    out_key_next   = '0;
                    out_tag_next   = '0;
                    was_empty_next = 1'b1;
                end
            end
            else if (count_reg < cap_reg)
            begin
                ctrl.mode  = MODE_INSERT;
                count_next = count_reg + 1'b1;
            end
            else if (key > cell_key[0])
            begin
                ctrl.mode = MODE_REPLACE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_key_reg   <= out_key_next;
        out_tag_reg   <= out_tag_next;
        was_empty_reg <= was_empty_next;
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign out_tag   = out_tag_reg;
    assign was_empty = was_empty_reg;

    // capacity register
    assign cfg_write = psel && penable && pwrite && pready;
    assign cap_value = pwdata[CAP_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CNT_W'(CAP_INIT);
        end
        else if (cfg_write && (paddr[2] == REG_CAPACITY) && (count_reg == '0)
                 && (cap_value != '0) && (32'(cap_value) <= 32'(DEPTH)))
        begin
            cap_reg <= CNT_W'(cap_value);
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? CFG_DATA_BITS'(cap_reg) : '0;

    // checks
    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("fill count above capacity");

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode) |=> out_valid)
        else $error("pop request gave no result");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(accept && opcode))
        else $error("result without a pop request");

    a_empty_pop_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode && (count_reg == '0)) |=> (count_reg == '0))
        else $error("pop on empty store changed the count");

endmodule

// ===== dv/tb_top_n_key_selector.sv =====
// tb_top_n_key_selector: self-checking bench for the top-n key selector
// offers and pops go through the start/busy port, capacity through apb; a
// local copy of the retained set predicts pops. depends on tnks_pkg
`timescale 1ns / 100ps

module tb_top_n_key_selector;

    localparam int DEPTH    = 256;
    localparam int KEY_BITS = 31;
    localparam int TAG_BITS = 16;
    localparam int CFG_BITS = tnks_pkg::CFG_DATA_BITS;

    localparam logic [KEY_BITS-1:0] KEY_MAX  = '1;
    localparam logic [TAG_BITS-1:0] TAG_MAX  = '1;
    localparam logic [2:0]          CAP_ADDR = {tnks_pkg::REG_CAPACITY, 2'b00};

    localparam int RAND_ITEMS   = 1750;
    localparam int SETTLE       = 32;
    localparam int FINAL_WAIT   = 20000;
    localparam int MAX_REPORTS  = 10;
    localparam longint TIMEOUT_NS = 64'd20_000_000;

    typedef enum logic { OP_OFFER = 1'b0, OP_POP = 1'b1 } op_e;
    typedef enum logic [1:0] { ROW_OFFER, ROW_POP, ROW_CAP } row_kind_e;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        logic                empty;
    } pop_result_t;

    // one line of the directed table; cap_value only matters for ROW_CAP
    typedef struct packed {
        row_kind_e           kind;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         cap_value;
        logic                has_exp;
        logic [KEY_BITS-1:0] exp_key;
        logic [TAG_BITS-1:0] exp_tag;
        logic                exp_empty;
    } dir_row_t;

    localparam int DIR_N = 28;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // pop straight out of reset finds nothing
        '{ROW_POP,   0,       0,       0, 1, 0,       0,       1},
        // extremes of key and tag
        '{ROW_OFFER, KEY_MAX, TAG_MAX, 0, 0, 0,       0,       0},
        '{ROW_OFFER, 0,       0,       0, 0, 0,       0,       0},
        '{ROW_POP,   0,       0,       0, 1, 0,       0,       0},
        '{ROW_POP,   0,       0,       0, 1, KEY_MAX, TAG_MAX, 0},
        '{ROW_POP,   0,       0,       0, 1, 0,       0,       1},
        // zero, above depth and over-wide capacity values are dropped
        '{ROW_CAP,   0,       0,       32'd0,     0, 0, 0, 0},
        '{ROW_CAP,   0,       0,       32'd257,   0, 0, 0, 0},
        '{ROW_CAP,   0,       0,       32'h200,   0, 0, 0, 0},
        '{ROW_CAP,   0,       0,       32'd1,     0, 0, 0, 0},
        // full at one entry: equal and lower keys dropped, higher replaces
        '{ROW_OFFER, 100,     5,       0, 0, 0,       0,       0},
        '{ROW_OFFER, 100,     9,       0, 0, 0,       0,       0},
        '{ROW_OFFER, 99,      1,       0, 0, 0,       0,       0},
        '{ROW_OFFER, 101,     3,       0, 0, 0,       0,       0},
        '{ROW_POP,   0,       0,       0, 1, 101,     3,       0},
        '{ROW_CAP,   0,       0,       32'd2,     0, 0, 0, 0},
        // equal minimum keys: smaller tag is the one replaced
        '{ROW_OFFER, 50,      7,       0, 0, 0,       0,       0},
        '{ROW_OFFER, 50,      2,       0, 0, 0,       0,       0},
        // capacity write while holding entries is ignored
        '{ROW_CAP,   0,       0,       32'd1,     0, 0, 0, 0},
        '{ROW_OFFER, 60,      1,       0, 0, 0,       0,       0},
        '{ROW_POP,   0,       0,       0, 0, 0,       0,       0},
        '{ROW_POP,   0,       0,       0, 0, 0,       0,       0},
        '{ROW_POP,   0,       0,       0, 1, 0,       0,       1},
        // alternating bit patterns
        '{ROW_OFFER, 31'h2AAA_AAAA, 16'h5555, 0, 0, 0, 0, 0},
        '{ROW_OFFER, 31'h5555_5555, 16'hAAAA, 0, 0, 0, 0, 0},
        '{ROW_POP,   0,       0,       0, 0, 0,       0,       0},
        '{ROW_POP,   0,       0,       0, 0, 0,       0,       0},
        '{ROW_CAP,   0,       0,       32'd256,   0, 0, 0, 0}
    };

    // dut ports
    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                start   = 1'b0;
    logic                opcode  = 1'b0;
    logic [KEY_BITS-1:0] key     = '0;
    logic [TAG_BITS-1:0] tag     = '0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [2:0]          paddr   = '0;
    logic [CFG_BITS-1:0] pwdata  = '0;
    logic                busy;
    logic                out_valid;
    logic [KEY_BITS-1:0] out_key;
    logic [TAG_BITS-1:0] out_tag;
    logic                was_empty;
    logic [CFG_BITS-1:0] prdata;
    logic                pready;

    // typed expectation riding along with the current request
    logic        row_has_exp = 1'b0;
    pop_result_t row_exp     = '0;

    // predicted retained set
    logic [KEY_BITS-1:0] kept_key [DEPTH];
    logic [TAG_BITS-1:0] kept_tag [DEPTH];
    int unsigned         kept_count = 0;
    int unsigned         kept_cap   = tnks_pkg::CAP_RESET;

    pop_result_t popped_due [$];

    int unsigned mismatches   = 0;
    int unsigned n_offers     = 0;
    int unsigned n_pops       = 0;
    int unsigned n_empty_pops = 0;
    int unsigned n_cap_writes = 0;
    int unsigned burst_left   = 1;

    top_n_key_selector #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .key       (key),
        .tag       (tag),
        .out_valid (out_valid),
        .out_key   (out_key),
        .out_tag   (out_tag),
        .was_empty (was_empty),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void note_mismatch(string msg);
        if (mismatches < MAX_REPORTS)
            $display("%s", msg);
        mismatches++;
    endfunction

    // key first, tag breaks ties
    function automatic bit entry_below(logic [KEY_BITS-1:0] ka, logic [TAG_BITS-1:0] ta,
                                       logic [KEY_BITS-1:0] kb, logic [TAG_BITS-1:0] tb);
        return (ka < kb) || (ka == kb && ta < tb);
    endfunction

    function automatic int unsigned smallest_slot();
        int unsigned best;
        best = 0;
        for (int unsigned i = 1; i < kept_count; i++)
            if (entry_below(kept_key[i], kept_tag[i], kept_key[best], kept_tag[best]))
                best = i;
        return best;
    endfunction

    function automatic void retain_offer(logic [KEY_BITS-1:0] k, logic [TAG_BITS-1:0] t);
        int unsigned s;
        if (kept_count < kept_cap && kept_count < DEPTH)
        begin
            kept_key[kept_count] = k;
            kept_tag[kept_count] = t;
            kept_count++;
        end
        else if (kept_count > 0)
        begin
            s = smallest_slot();
            if (k > kept_key[s])
            begin
                kept_key[s] = k;
                kept_tag[s] = t;
            end
        end
    endfunction

    function automatic pop_result_t remove_smallest();
        pop_result_t r;
        int unsigned s;
        r = '0;
        if (kept_count == 0)
        begin
            r.empty = 1'b1;
            return r;
        end
        s = smallest_slot();
        r.key = kept_key[s];
        r.tag = kept_tag[s];
        kept_count--;
        kept_key[s] = kept_key[kept_count];
        kept_tag[s] = kept_tag[kept_count];
        return r;
    endfunction

    function automatic void apply_capacity_write(logic [31:0] value);
        int unsigned v;
        v = 32'(value[tnks_pkg::CAP_BITS-1:0]);
        if (kept_count == 0 && v >= 1 && v <= DEPTH)
            kept_cap = v;
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key(bit narrow);
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return KEY_MAX;
        if (narrow)
            return KEY_BITS'($urandom_range(0, 7));
        return KEY_BITS'($urandom());
    endfunction

    function automatic logic [TAG_BITS-1:0] pick_tag(bit narrow);
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return TAG_MAX;
        if (narrow)
            return TAG_BITS'($urandom_range(0, 3));
        return TAG_BITS'($urandom());
    endfunction

    // request acceptance feeds the predictor, then results are checked
    always @(posedge clk)
    begin : watch
        pop_result_t want;
        pop_result_t got;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (opcode == OP_OFFER)
                begin
                    retain_offer(key, tag);
                    n_offers++;
                end
                else
                begin
                    want = remove_smallest();
                    if (row_has_exp)
                        want = row_exp;
                    popped_due.push_back(want);
                    n_pops++;
                end
            end
            if (out_valid)
            begin
                got = '{key: out_key, tag: out_tag, empty: was_empty};
                if (got.empty === 1'b1)
                    n_empty_pops++;
                if (popped_due.size() == 0)
                    note_mismatch($sformatf("unexpected result: key %h tag %h empty %b",
                                            got.key, got.tag, got.empty));
                else
                begin
                    want = popped_due.pop_front();
                    if (got.key !== want.key || got.tag !== want.tag
                        || got.empty !== want.empty)
                        note_mismatch($sformatf(
                            "pop mismatch: expected key %h tag %h empty %b, got key %h tag %h empty %b",
                            want.key, want.tag, want.empty, got.key, got.tag, got.empty));
                end
            end
        end
    end

    // present one request and hold it until accepted
    task automatic send_request(op_e op, logic [KEY_BITS-1:0] k, logic [TAG_BITS-1:0] t,
                                logic has_exp, pop_result_t want);
        start       <= 1'b1;
        opcode      <= op;
        key         <= k;
        tag         <= t;
        row_has_exp <= has_exp;
        row_exp     <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // sender gap, short or until every pending pop has come back
    task automatic pause_sender(bit until_drained);
        start <= 1'b0;
        if (until_drained)
        begin
            @(posedge clk);
            while (popped_due.size() != 0)
                @(posedge clk);
        end
        else
            repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    // bring the block to idle before a register write
    task automatic settle_idle();
        pause_sender(1'b1);
        repeat (SETTLE) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // apb write of capacity followed by a read back
    task automatic write_capacity(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        apply_capacity_write(value);
        n_cap_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== CFG_BITS'(kept_cap))
            note_mismatch($sformatf("capacity read back: expected %0d, got %0d",
                                    kept_cap, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin : stimulus
        dir_row_t    row;
        pop_result_t row_want;
        int unsigned rand_items;
        int unsigned phase;
        int unsigned len;
        int unsigned offer_pct;
        int unsigned waited;
        logic [31:0] cap_pick;
        bit          narrow;
        bit          no_gap;
        op_e         op;

        rand_items = 0;
        phase      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_N; i++)
        begin
            row = DIR_ROWS[i];
            row_want = '{key: row.exp_key, tag: row.exp_tag, empty: row.exp_empty};
            case (row.kind)
                ROW_CAP:
                begin
                    settle_idle();
                    write_capacity(row.cap_value);
                end
                ROW_POP:   send_request(OP_POP, '0, '0, row.has_exp, row_want);
                default:   send_request(OP_OFFER, row.key, row.tag, 1'b0, '0);
            endcase
        end

        // random phases, each at its own capacity and offer/pop mix
        while (rand_items < RAND_ITEMS)
        begin
            if (phase == 0)
            begin
                cap_pick  = tnks_pkg::CAP_RESET;
                len       = 320;
                offer_pct = 90;
                narrow    = 1'b0;
                no_gap    = 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       cap_pick = 1;
                    1:       cap_pick = 2;
                    2, 3, 4: cap_pick = $urandom_range(3, 8);
                    5, 6:    cap_pick = $urandom_range(9, 40);
                    7:       cap_pick = $urandom_range(41, 255);
                    8:       cap_pick = DEPTH;
                    default: cap_pick = ($urandom_range(0, 1) == 0)
                                        ? 32'd0 : $urandom_range(257, 511);
                endcase
                if ($urandom_range(0, 5) == 0)
                    cap_pick[31:tnks_pkg::CAP_BITS] = (32 - tnks_pkg::CAP_BITS)'($urandom());
                len = $urandom_range(15, 90);
                case ($urandom_range(0, 2))
                    0:       offer_pct = 85;
                    1:       offer_pct = 60;
                    default: offer_pct = 35;
                endcase
                narrow = ($urandom_range(0, 2) == 0);
                no_gap = ($urandom_range(0, 3) == 0);
            end

            // mostly empty the store so the new capacity takes hold
            settle_idle();
            if (phase == 0 || $urandom_range(0, 7) != 0)
            begin
                repeat (kept_count)
                begin
                    send_request(OP_POP, '0, '0, 1'b0, '0);
                    rand_items++;
                end
                settle_idle();
            end
            write_capacity(cap_pick);

            for (int unsigned n = 0; n < len; n++)
            begin
                op = ($urandom_range(1, 100) <= offer_pct) ? OP_OFFER : OP_POP;
                if (op == OP_OFFER)
                    send_request(OP_OFFER, pick_key(narrow), pick_tag(narrow), 1'b0, '0);
                else
                    send_request(OP_POP, pick_key(1'b0), pick_tag(1'b0), 1'b0, '0);
                rand_items++;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    if (!no_gap)
                        pause_sender($urandom_range(0, 39) == 0);
                end
            end
            phase++;
        end

        // wait out the last results
        start <= 1'b0;
        waited = 0;
        while (popped_due.size() != 0 && waited < FINAL_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        if (popped_due.size() != 0)
            note_mismatch($sformatf("%0d pop results never arrived", popped_due.size()));

        $display("covered %0d offers and %0d pops (%0d on an empty store) over %0d phases",
                 n_offers, n_pops, n_empty_pops, phase);
        $display("capacity written %0d times, %0d mismatches", n_cap_writes, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hard stop if the block stalls
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d pop results pending", popped_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
